// ----- hw/rtl/tscm_pkg.sv -----
package tscm_pkg;

  localparam int PidEntries = 8192;
  localparam int CountWidth = 48;
  localparam int IdxWidth   = $clog2(PidEntries);
  localparam int OutWidth   = 48;

  localparam logic [7:0]  SyncValue = 8'h47;
  localparam logic [12:0] NullPid   = 13'h1fff;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic        transport_error;
    logic [12:0] pid;
    logic [1:0]  scrambling_bits;
    logic        has_payload;
    logic [3:0]  continuity;
  } in_t;

  typedef struct packed {
    logic [OutWidth-1:0] packets_seen;
    logic [OutWidth-1:0] error_packets;
    logic [OutWidth-1:0] sequence_errors;
    logic [OutWidth-1:0] scrambled_packets;
    logic                header_bad;
    logic                sequence_bad;
    logic                is_scrambled;
  } out_t;

  // One PID table entry: seen flag and the last continuity counter
  typedef struct packed {
    logic       seen;
    logic [3:0] cc;
  } entry_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == {CountWidth{1'b1}}) ? v : v + CountWidth'(1);
  endfunction

  function automatic logic [OutWidth-1:0] to_out(input logic [CountWidth-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    to_out = w[OutWidth-1:0];
  endfunction

endpackage

// ----- hw/rtl/ts_continuity_monitor_core.sv -----
// Transport stream continuity monitor.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one decoded packet
// header per transfer. Output channel (out_valid_o/out_ready_i/out_data_o)
// gives exactly one result per header: the four running counters after this
// packet (saturating) and the per-packet header, sequence and scramble flags.
// The PID table (seen flag plus last counter) sits in one synchronous RAM of
// tscm_pkg::PidEntries entries with a registered read. A header is read from
// the RAM at its accepting edge into the check stage, checked and written
// back there, and its result is registered in the output register. While
// out_ready_i stays high, one header per cycle is sustained; a write-back
// register forwards the latest table update to the header right behind it.
// After reset the block clears the table one entry per cycle, with in_ready_o
// low; the counters reset to zero. When the receiver stalls, the output
// register holds its result; the check stage keeps at most one more header
// and then in_ready_o drops until the output transfer happens.
module ts_continuity_monitor_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tscm_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tscm_pkg::out_t  out_data_o
);

  localparam int IdxW = tscm_pkg::IdxWidth;
  localparam int CntW = tscm_pkg::CountWidth;

  tscm_pkg::entry_t mem [tscm_pkg::PidEntries];

  logic                 clr_q;
  logic [IdxW-1:0]      clr_idx_q;
  logic                 s1_vld_q;
  tscm_pkg::in_t        s1_q;
  tscm_pkg::entry_t     rdata_q;
  logic                 fwd_vld_q;
  logic [IdxW-1:0]      fwd_addr_q;
  tscm_pkg::entry_t     fwd_data_q;
  logic                 out_vld_q;
  tscm_pkg::out_t       out_q;
  logic [CntW-1:0]      tot_q, err_q, mis_q, scr_q;
  logic [CntW-1:0]      tot_d, err_d, mis_d, scr_d;

  logic                 in_xfer;
  logic                 s1_go;
  logic [IdxW-1:0]      s1_idx;
  tscm_pkg::entry_t     cur;
  logic                 hdr_bad, non_null, scrambled, in_table, seq_bad;
  logic [3:0]           expect_cc;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  tscm_pkg::entry_t     wr_data;

  assign s1_go      = s1_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !clr_q && (!s1_vld_q || s1_go);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s1_idx     = s1_q.pid[IdxW-1:0];

  always_comb begin
    // take the latest write-back when it hit the same entry as our read
    cur       = (fwd_vld_q && fwd_addr_q == s1_idx) ? fwd_data_q : rdata_q;
    hdr_bad   = (s1_q.sync_byte != tscm_pkg::SyncValue) || s1_q.transport_error;
    non_null  = !hdr_bad && (s1_q.pid != tscm_pkg::NullPid);
    scrambled = non_null && (s1_q.scrambling_bits != 2'd0);
    in_table  = non_null && (32'(s1_q.pid) < 32'(tscm_pkg::PidEntries));
    expect_cc = s1_q.has_payload ? cur.cc + 4'd1 : cur.cc;
    seq_bad   = in_table && cur.seen && (s1_q.continuity != expect_cc);

    tot_d = tscm_pkg::sat_inc(tot_q);
    err_d = hdr_bad ? tscm_pkg::sat_inc(err_q) : err_q;
    mis_d = seq_bad ? tscm_pkg::sat_inc(mis_q) : mis_q;
    scr_d = scrambled ? tscm_pkg::sat_inc(scr_q) : scr_q;

    if (clr_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_q;
      wr_data = '0;
    end else begin
      wr_en   = s1_go && in_table;
      wr_addr = s1_idx;
      wr_data = '{seen: 1'b1, cc: s1_q.continuity};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_xfer) begin
      rdata_q <= mem[in_data_i.pid[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      tot_q     <= '0;
      err_q     <= '0;
      mis_q     <= '0;
      scr_q     <= '0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
        if (clr_idx_q == IdxW'(tscm_pkg::PidEntries - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (in_xfer) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (!clr_q && wr_en) begin
        fwd_vld_q <= 1'b1;
      end
      if (s1_go) begin
        out_vld_q <= 1'b1;
        tot_q     <= tot_d;
        err_q     <= err_d;
        mis_q     <= mis_d;
        scr_q     <= scr_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
    if (!clr_q && wr_en) begin
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
    if (s1_go) begin
      out_q.packets_seen      <= tscm_pkg::to_out(tot_d);
      out_q.error_packets     <= tscm_pkg::to_out(err_d);
      out_q.sequence_errors   <= tscm_pkg::to_out(mis_d);
      out_q.scrambled_packets <= tscm_pkg::to_out(scr_d);
      out_q.header_bad        <= hdr_bad;
      out_q.sequence_bad      <= seq_bad;
      out_q.is_scrambled      <= scrambled;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !s1_vld_q && !out_vld_q)
    else $error("header in flight during table clear");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.header_bad |-> !out_q.sequence_bad && !out_q.is_scrambled)
    else $error("error packet also flagged as sequence or scramble");

  a_total_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> (tot_q != $past(tot_q)) || (tot_q == {CntW{1'b1}}))
    else $error("packet counter did not advance");
`endif

endmodule
